// File: design/serl_pkg.sv
package serl_pkg;

   localparam int unsigned STEER_FULL_SCALE_DEFAULT = 32638;

   // field widths
   localparam int unsigned STEER_W   = 16;
   localparam int unsigned PEDAL_W   = 8;
   localparam int unsigned DIR_W     = 2;
   localparam int unsigned ANGLE_W   = 8;
   localparam int unsigned PERCENT_W = 7;
   localparam int unsigned DZ_W      = 15;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 15;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_ZONE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EXPO_PERCENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_STEP    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SERVO_LIMIT  = 2'd3;

   // register reset values
   localparam logic [DZ_W-1:0]      DEAD_ZONE_RESET    = 15'd800;
   localparam logic [PERCENT_W-1:0] EXPO_PERCENT_RESET = 7'd30;
   localparam logic [PERCENT_W-1:0] RATE_STEP_RESET    = 7'd2;
   localparam logic [PERCENT_W-1:0] SERVO_LIMIT_RESET  = 7'd20;

   // shaping constants
   localparam int unsigned PER_MILLE   = 1000;
   localparam int unsigned MILLION     = 1000 * 1000;
   localparam int unsigned PERCENT_MAX = 100;
   localparam int unsigned ANGLE_MAX   = 90;

   // datapath micro-operations
   localparam int unsigned OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
   localparam logic [OP_W-1:0] OP_CAPTURE = 4'd1;
   localparam logic [OP_W-1:0] OP_MAG     = 4'd2;
   localparam logic [OP_W-1:0] OP_LOADX   = 4'd3;
   localparam logic [OP_W-1:0] OP_DIV_A   = 4'd4;
   localparam logic [OP_W-1:0] OP_DIV_B   = 4'd5;
   localparam logic [OP_W-1:0] OP_DIV_C   = 4'd6;
   localparam logic [OP_W-1:0] OP_SQUARE  = 4'd7;
   localparam logic [OP_W-1:0] OP_CUBE    = 4'd8;
   localparam logic [OP_W-1:0] OP_LIN     = 4'd9;
   localparam logic [OP_W-1:0] OP_CUBW    = 4'd10;
   localparam logic [OP_W-1:0] OP_SUM     = 4'd11;
   localparam logic [OP_W-1:0] OP_MUL_FS  = 4'd12;
   localparam logic [OP_W-1:0] OP_MUL_LIM = 4'd13;
   localparam logic [OP_W-1:0] OP_RATE    = 4'd14;

   // divisor select
   localparam logic [1:0] DIV_FS  = 2'd0;
   localparam logic [1:0] DIV_MIL = 2'd1;
   localparam logic [1:0] DIV_HUN = 2'd2;
   localparam logic [1:0] DIV_THO = 2'd3;

   typedef struct packed {
      logic [DZ_W-1:0]      dead_zone;
      logic [PERCENT_W-1:0] expo_percent;
      logic [PERCENT_W-1:0] rate_step;
      logic [PERCENT_W-1:0] servo_limit;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      div_sel;
   } cmd_type;

   typedef struct packed {
      logic early;
      logic out_full;
   } status_type;

endpackage

// File: design/serl_csr.sv
module serl_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [serl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [serl_pkg::CSR_DAT_W-1:0] csr_wdata,
   output serl_pkg::cfg_type              cfg
);
   import serl_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DEAD_ZONE:    cfg_in.dead_zone    = csr_wdata[DZ_W-1:0];
            REG_EXPO_PERCENT: cfg_in.expo_percent = csr_wdata[PERCENT_W-1:0];
            REG_RATE_STEP:    cfg_in.rate_step    = csr_wdata[PERCENT_W-1:0];
            REG_SERVO_LIMIT:  cfg_in.servo_limit  = csr_wdata[PERCENT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone    <= DEAD_ZONE_RESET;
         cfg_ff.expo_percent <= EXPO_PERCENT_RESET;
         cfg_ff.rate_step    <= RATE_STEP_RESET;
         cfg_ff.servo_limit  <= SERVO_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/serl_ctrl.sv
module serl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  serl_pkg::status_type status,
   output serl_pkg::cmd_type    cmd
);
   import serl_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MAG  = 5'd1;
   localparam logic [4:0] S_N0   = 5'd2;
   localparam logic [4:0] S_N1   = 5'd3;
   localparam logic [4:0] S_N2   = 5'd4;
   localparam logic [4:0] S_SQ   = 5'd5;
   localparam logic [4:0] S_CU   = 5'd6;
   localparam logic [4:0] S_C0   = 5'd7;
   localparam logic [4:0] S_C1   = 5'd8;
   localparam logic [4:0] S_C2   = 5'd9;
   localparam logic [4:0] S_M0   = 5'd10;
   localparam logic [4:0] S_M1   = 5'd11;
   localparam logic [4:0] S_M2   = 5'd12;
   localparam logic [4:0] S_M3   = 5'd13;
   localparam logic [4:0] S_M4   = 5'd14;
   localparam logic [4:0] S_M5   = 5'd15;
   localparam logic [4:0] S_S0   = 5'd16;
   localparam logic [4:0] S_S1   = 5'd17;
   localparam logic [4:0] S_S2   = 5'd18;
   localparam logic [4:0] S_S3   = 5'd19;
   localparam logic [4:0] S_T0   = 5'd20;
   localparam logic [4:0] S_T1   = 5'd21;
   localparam logic [4:0] S_T2   = 5'd22;
   localparam logic [4:0] S_T3   = 5'd23;
   localparam logic [4:0] S_RATE = 5'd24;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.op      = OP_NONE;
      cmd.div_sel = DIV_FS;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            cmd.op   = OP_MAG;
            state_in = status.early ? S_RATE : S_N0;
         end
         S_N0: begin cmd.op = OP_LOADX; state_in = S_N1; end
         S_N1: begin cmd.op = OP_DIV_B; state_in = S_N2; end
         S_N2: begin cmd.op = OP_DIV_C; state_in = S_SQ; end
         S_SQ: begin cmd.op = OP_SQUARE; state_in = S_CU; end
         S_CU: begin cmd.op = OP_CUBE; state_in = S_C0; end
         S_C0: begin cmd.op = OP_LOADX; cmd.div_sel = DIV_MIL; state_in = S_C1; end
         S_C1: begin cmd.op = OP_DIV_B; cmd.div_sel = DIV_MIL; state_in = S_C2; end
         S_C2: begin cmd.op = OP_DIV_C; cmd.div_sel = DIV_MIL; state_in = S_M0; end
         S_M0: begin cmd.op = OP_LIN; state_in = S_M1; end
         S_M1: begin cmd.op = OP_CUBW; state_in = S_M2; end
         S_M2: begin cmd.op = OP_SUM; state_in = S_M3; end
         S_M3: begin cmd.op = OP_DIV_A; cmd.div_sel = DIV_HUN; state_in = S_M4; end
         S_M4: begin cmd.op = OP_DIV_B; cmd.div_sel = DIV_HUN; state_in = S_M5; end
         S_M5: begin cmd.op = OP_DIV_C; cmd.div_sel = DIV_HUN; state_in = S_S0; end
         S_S0: begin cmd.op = OP_MUL_FS; state_in = S_S1; end
         S_S1: begin cmd.op = OP_LOADX; cmd.div_sel = DIV_THO; state_in = S_S2; end
         S_S2: begin cmd.op = OP_DIV_B; cmd.div_sel = DIV_THO; state_in = S_S3; end
         S_S3: begin cmd.op = OP_DIV_C; cmd.div_sel = DIV_THO; state_in = S_T0; end
         S_T0: begin cmd.op = OP_MUL_LIM; state_in = S_T1; end
         S_T1: begin cmd.op = OP_LOADX; state_in = S_T2; end
         S_T2: begin cmd.op = OP_DIV_B; state_in = S_T3; end
         S_T3: begin cmd.op = OP_DIV_C; state_in = S_RATE; end
         S_RATE: begin
            // hold until the output register is free
            if (!status.out_full) begin
               cmd.op   = OP_RATE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/serl_dp.sv
module serl_dp #(
   parameter int unsigned STEER_FULL_SCALE = serl_pkg::STEER_FULL_SCALE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  serl_pkg::cmd_type                   cmd,
   output serl_pkg::status_type                status,
   input  serl_pkg::cfg_type                   cfg,
   input  logic signed [serl_pkg::STEER_W-1:0] req_steer_in,
   input  logic signed [serl_pkg::PEDAL_W-1:0] req_throttle_in,
   input  logic signed [serl_pkg::PEDAL_W-1:0] req_brake_in,
   input  logic [serl_pkg::DIR_W-1:0]          req_direction_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [serl_pkg::ANGLE_W-1:0] rsp_steer_angle,
   output logic [serl_pkg::DIR_W-1:0]          rsp_drive_mode,
   output logic [serl_pkg::PERCENT_W-1:0]      rsp_drive_speed,
   output logic [serl_pkg::PERCENT_W-1:0]      rsp_drive_brake
);
   import serl_pkg::*;

   localparam int unsigned RECIP_SHIFT = 32;
   localparam int unsigned RECIP_W     = 26;
   localparam int unsigned MUL_A_W     = 30;
   localparam int unsigned PROD_W      = 48;
   localparam int unsigned DIVISOR_W   = 20;
   localparam int unsigned Q_W         = 16;
   localparam int unsigned NORM_W      = 10;

   localparam logic [RECIP_W-1:0] RECIP_FS  =
      RECIP_W'((64'd1 << RECIP_SHIFT) / STEER_FULL_SCALE);
   localparam logic [RECIP_W-1:0] RECIP_MIL = RECIP_W'((64'd1 << RECIP_SHIFT) / MILLION);
   localparam logic [RECIP_W-1:0] RECIP_HUN = RECIP_W'((64'd1 << RECIP_SHIFT) / PERCENT_MAX);
   localparam logic [RECIP_W-1:0] RECIP_THO = RECIP_W'((64'd1 << RECIP_SHIFT) / PER_MILLE);
   localparam logic [DZ_W-1:0]    FULL_SCALE = DZ_W'(STEER_FULL_SCALE);

   // captured item
   logic signed [STEER_W-1:0] steer_ff;
   logic signed [PEDAL_W-1:0] thr_ff, brk_ff;
   logic [DIR_W-1:0]          dir_ff;

   // working registers
   logic [PROD_W-1:0]  prod_ff;
   logic [MUL_A_W-1:0] x_ff;
   logic [Q_W-1:0]     q_ff;
   logic [NORM_W-1:0]  norm_ff;
   logic               zero_ff, full_ff;

   // result registers, angle_ff holds the last angle and doubles as the emitted angle
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic [DIR_W-1:0]          mode_ff;
   logic [PERCENT_W-1:0]      speed_ff, brake_ff;
   logic                      valid_ff;

   logic [STEER_W-1:0]       mag;
   logic                     mag_zero, mag_full;
   logic [PERCENT_W-1:0]     expo, lim;
   logic [RECIP_W-1:0]       recip;
   logic [DIVISOR_W-1:0]     divisor;
   logic [MUL_A_W-1:0]       mul_a;
   logic [RECIP_W-1:0]       mul_b;
   logic [MUL_A_W+RECIP_W-1:0] mul_p;
   logic [Q_W-1:0]           q_est;
   logic [MUL_A_W-1:0]       rem;
   logic [PERCENT_W-1:0]     tgt_mag;
   logic signed [ANGLE_W-1:0] target;
   logic signed [9:0]        delta, step;

   function automatic logic [PERCENT_W-1:0] sat_percent(input logic signed [PEDAL_W-1:0] v);
      logic [PERCENT_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(PEDAL_W'(PERCENT_MAX))) begin
         r = PERCENT_W'(PERCENT_MAX);
      end else begin
         r = v[PERCENT_W-1:0];
      end
      return r;
   endfunction

   // magnitude; the most negative sample gives 32768
   assign mag      = steer_ff[STEER_W-1] ? (~steer_ff + 1'b1) : steer_ff;
   assign mag_zero = mag < {1'b0, cfg.dead_zone};
   // at or above full scale the curve and clamp both land on the limit
   assign mag_full = mag >= {1'b0, FULL_SCALE};

   assign expo = (cfg.expo_percent > PERCENT_W'(PERCENT_MAX)) ?
                 PERCENT_W'(PERCENT_MAX) : cfg.expo_percent;
   assign lim  = (cfg.servo_limit > PERCENT_W'(ANGLE_MAX)) ?
                 PERCENT_W'(ANGLE_MAX) : cfg.servo_limit;

   always_comb begin
      case (cmd.div_sel)
         DIV_FS:  begin recip = RECIP_FS;  divisor = DIVISOR_W'(STEER_FULL_SCALE); end
         DIV_MIL: begin recip = RECIP_MIL; divisor = DIVISOR_W'(MILLION); end
         DIV_HUN: begin recip = RECIP_HUN; divisor = DIVISOR_W'(PERCENT_MAX); end
         DIV_THO: begin recip = RECIP_THO; divisor = DIVISOR_W'(PER_MILLE); end
         default: begin recip = RECIP_FS;  divisor = DIVISOR_W'(STEER_FULL_SCALE); end
      endcase
   end

   // reciprocal estimate is at most one short
   assign q_est = prod_ff[RECIP_SHIFT +: Q_W];
   assign rem   = x_ff - prod_ff[MUL_A_W-1:0];

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MAG:     begin mul_a = MUL_A_W'(mag); mul_b = RECIP_W'(PER_MILLE); end
         OP_LOADX:   begin mul_a = prod_ff[MUL_A_W-1:0]; mul_b = recip; end
         OP_DIV_A:   begin mul_a = x_ff; mul_b = recip; end
         OP_DIV_B:   begin mul_a = MUL_A_W'(q_est); mul_b = RECIP_W'(divisor); end
         OP_SQUARE:  begin mul_a = MUL_A_W'(q_ff[NORM_W-1:0]); mul_b = RECIP_W'(q_ff[NORM_W-1:0]); end
         OP_CUBE:    begin mul_a = prod_ff[MUL_A_W-1:0]; mul_b = RECIP_W'(norm_ff); end
         OP_LIN: begin
            mul_a = MUL_A_W'(norm_ff);
            mul_b = RECIP_W'(PERCENT_W'(PERCENT_MAX) - expo);
         end
         OP_CUBW:    begin mul_a = MUL_A_W'(q_ff); mul_b = RECIP_W'(expo); end
         OP_MUL_FS:  begin mul_a = MUL_A_W'(q_ff); mul_b = RECIP_W'(FULL_SCALE); end
         OP_MUL_LIM: begin mul_a = MUL_A_W'(q_ff); mul_b = RECIP_W'(lim); end
         default:    begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // rate limiter
   assign tgt_mag = zero_ff ? '0 : (full_ff ? lim : q_ff[PERCENT_W-1:0]);
   assign target  = steer_ff[STEER_W-1] ? -$signed({1'b0, tgt_mag}) : $signed({1'b0, tgt_mag});
   assign step    = $signed({3'b000, cfg.rate_step});

   always_comb begin
      delta = 10'(target) - 10'(angle_ff);
      if (delta > step) begin
         delta = step;
      end else if (delta < -step) begin
         delta = -step;
      end
      angle_in = angle_ff + delta[ANGLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            steer_ff <= req_steer_in;
            thr_ff   <= req_throttle_in;
            brk_ff   <= req_brake_in;
            dir_ff   <= req_direction_in;
         end
         OP_MAG: begin
            zero_ff <= mag_zero;
            full_ff <= mag_full;
            prod_ff <= PROD_W'(mul_p);
         end
         OP_LOADX: begin
            x_ff    <= prod_ff[MUL_A_W-1:0];
            prod_ff <= PROD_W'(mul_p);
         end
         OP_DIV_A:  prod_ff <= PROD_W'(mul_p);
         OP_DIV_B: begin
            q_ff    <= q_est;
            prod_ff <= PROD_W'(mul_p);
         end
         OP_DIV_C: begin
            if (rem >= MUL_A_W'(divisor)) begin
               q_ff <= q_ff + 1'b1;
            end
         end
         OP_SQUARE: begin
            norm_ff <= q_ff[NORM_W-1:0];
            prod_ff <= PROD_W'(mul_p);
         end
         OP_CUBE:    prod_ff <= PROD_W'(mul_p);
         OP_LIN:     prod_ff <= PROD_W'(mul_p);
         OP_CUBW: begin
            x_ff    <= prod_ff[MUL_A_W-1:0];
            prod_ff <= PROD_W'(mul_p);
         end
         OP_SUM:     x_ff <= x_ff + prod_ff[MUL_A_W-1:0];
         OP_MUL_FS:  prod_ff <= PROD_W'(mul_p);
         OP_MUL_LIM: prod_ff <= PROD_W'(mul_p);
         OP_RATE: begin
            mode_ff  <= dir_ff;
            speed_ff <= sat_percent(thr_ff);
            brake_ff <= sat_percent(brk_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_RATE) begin
            angle_ff <= angle_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign status.early    = mag_zero | mag_full;
   assign status.out_full = valid_ff & ~rsp_ready;

   assign rsp_valid       = valid_ff;
   assign rsp_steer_angle = angle_ff;
   assign rsp_drive_mode  = mode_ff;
   assign rsp_drive_speed = speed_ff;
   assign rsp_drive_brake = brake_ff;

endmodule

// File: design/steering_expo_rate_limit_top.sv
// a shaped sample walks the curve and divide steps after the request transfer before the response is valid;
// a sample in the dead zone or at or beyond full scale skips them and goes straight to the rate step
// one item at a time: a new request is taken only once the last one is in the output
// register, the sequencer stepping one shared multiplier through the curve and its divide-by-constant steps
// reset: synchronous active high, registers back to defaults, last angle cleared
module steering_expo_rate_limit_top #(
   parameter int unsigned STEER_FULL_SCALE = serl_pkg::STEER_FULL_SCALE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [serl_pkg::STEER_W-1:0] req_steer_in,
   input  logic signed [serl_pkg::PEDAL_W-1:0] req_throttle_in,
   input  logic signed [serl_pkg::PEDAL_W-1:0] req_brake_in,
   input  logic [serl_pkg::DIR_W-1:0]          req_direction_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [serl_pkg::ANGLE_W-1:0] rsp_steer_angle,
   output logic [serl_pkg::DIR_W-1:0]          rsp_drive_mode,
   output logic [serl_pkg::PERCENT_W-1:0]      rsp_drive_speed,
   output logic [serl_pkg::PERCENT_W-1:0]      rsp_drive_brake,
   // register write port
   input  logic                                csr_we,
   input  logic [serl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [serl_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import serl_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // dead zone, expo, rate step and servo limit registers
   serl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: takes a transfer only when idle, walks the shaping steps (skipping them
   // for dead zone or full-scale samples), then waits for the output register to free up before loading it
   serl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: capture, magnitude, shared multiplier with reciprocal
   // division and a one-step correction, slew limiter and output register
   serl_dp #(
      .STEER_FULL_SCALE (STEER_FULL_SCALE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg              (cfg),
      .req_steer_in     (req_steer_in),
      .req_throttle_in  (req_throttle_in),
      .req_brake_in     (req_brake_in),
      .req_direction_in (req_direction_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_steer_angle  (rsp_steer_angle),
      .rsp_drive_mode   (rsp_drive_mode),
      .rsp_drive_speed  (rsp_drive_speed),
      .rsp_drive_brake  (rsp_drive_brake)
   );

`ifndef SYNTH
   // one item at a time: no second transfer right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // the slew limited angle never leaves the servo range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_steer_angle <= $signed(ANGLE_W'(ANGLE_MAX)) &&
                     rsp_steer_angle >= -$signed(ANGLE_W'(ANGLE_MAX))))
      else $error("servo angle out of range");

   // saturated pedal values stay within percent range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_speed <= PERCENT_W'(PERCENT_MAX) &&
                     rsp_drive_brake <= PERCENT_W'(PERCENT_MAX)))
      else $error("motor percent out of range");
`endif

endmodule
